/* src/assert_macros.svh */
// Assertion macros used by the top level of the scheduler.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/plls_pkg.sv */
// Package for the periodic least-laxity scheduler: sizes, command codes
// and the task entry type. Depends on nothing.
package plls_pkg;

  localparam int MAX_TASKS = 8;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int CFG_W     = 4;
  localparam int TIME_W    = 16;
  localparam int DL_W      = TIME_W + 1;
  localparam int LAX_W     = TIME_W + 2;
  localparam int JOB_W     = 16;

  // Most negative deadline counter value; the counter saturates here.
  localparam logic [DL_W-1:0] DL_MIN = {1'b1, {TIME_W{1'b0}}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] exec_len;
    logic [TIME_W-1:0] period_len;
    logic [TIME_W-1:0] deadline_len;
    logic [TIME_W-1:0] rw;
    logic [TIME_W-1:0] pl;
    logic [DL_W-1:0]   dl;
    logic [JOB_W-1:0]  job;
  } entry_t;

  typedef struct packed {
    entry_t            nxt;
    logic              take;
    logic signed [LAX_W-1:0] lax;
    logic              miss;
    logic              reload;
    logic              rw_one;
  } step_t;

endpackage

/* src/plls_step.sv */
// Per-slot tick arithmetic of the scheduler: laxity, compare against the
// running best, deadline and period countdown. Depends on plls_pkg.
module plls_step (
  input  plls_pkg::entry_t             cur,
  input  logic                         found,
  input  logic signed [plls_pkg::LAX_W-1:0] best_lax,
  output plls_pkg::step_t              res
);

  logic                              ready;
  logic signed [plls_pkg::LAX_W-1:0] lax;
  logic [plls_pkg::DL_W-1:0]         dl_dec;
  logic                              dl_le0;
  logic                              reload;

  always_comb begin
    ready  = (cur.rw != '0);
    lax    = plls_pkg::LAX_W'($signed(cur.dl)) - $signed({2'b00, cur.rw});
    dl_dec = (cur.dl == plls_pkg::DL_MIN) ? cur.dl : cur.dl - 1'b1;
    dl_le0 = dl_dec[plls_pkg::DL_W-1] || (dl_dec == '0);
    reload = (cur.pl <= plls_pkg::TIME_W'(1));

    res.take   = ready && (!found || (lax < best_lax));
    res.lax    = lax;
    res.miss   = dl_le0 && ready;
    res.reload = reload;
    res.rw_one = (cur.rw == plls_pkg::TIME_W'(1));

    res.nxt = cur;
    if (reload) begin
      res.nxt.rw  = cur.exec_len;
      res.nxt.pl  = cur.period_len;
      res.nxt.dl  = {1'b0, cur.deadline_len};
      res.nxt.job = cur.job + 1'b1;
    end else begin
      res.nxt.pl  = cur.pl - 1'b1;
      res.nxt.dl  = dl_dec;
    end
  end

endmodule

/* src/periodic_least_laxity_scheduler.sv */
// Top level of the periodic least-laxity scheduler: task table, scan
// sequencer and output register. Depends on plls_pkg, plls_step and assert_macros.svh.
//
//   channel  direction  handshake              payload
//   in_      request    in_valid / in_ready    cmd, task_slot, exec_time, period_len, deadline_len
//   out_     result     out_valid / out_ready  chosen_task, idle, job_number, miss_mask
//   cfg_     write      cfg_we                 cfg_wdata (tasks_in_use)
//
// A load request goes from the accepting cycle straight to the issue state. A tick request
// goes from the accepting cycle through a scan of the first n slots, one by one through the
// shared step unit, where n is tasks_in_use saturated to eight, then through the fix-up
// state and the issue state. A new request is accepted only once the block is back in idle.
// Reset (rst_n low, synchronous) clears the sequencer and sets tasks_in_use to 1, and
// in_ready stays low while it lasts; the task table is undefined until loaded. The next
// request is accepted while a result still waits; the block holds in the issue state only
// when the output is full and not being taken.
`include "assert_macros.svh"

module periodic_least_laxity_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [plls_pkg::SLOT_W-1:0]   in_task_slot,
  input  logic [plls_pkg::TIME_W-1:0]   in_exec_time,
  input  logic [plls_pkg::TIME_W-1:0]   in_period_len,
  input  logic [plls_pkg::TIME_W-1:0]   in_deadline_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [plls_pkg::SLOT_W-1:0]   out_chosen_task,
  output logic                          out_idle,
  output logic [plls_pkg::JOB_W-1:0]    out_job_number,
  output logic [plls_pkg::MAX_TASKS-1:0] out_miss_mask,
  input  logic                          cfg_we,
  input  logic [plls_pkg::CFG_W-1:0]    cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIX,
    S_ISSUE
  } state_t;

  state_t                          state_r;
  logic [plls_pkg::CFG_W-1:0]      tasks_in_use_r;
  logic [plls_pkg::CNT_W-1:0]      n_r;
  logic [plls_pkg::SLOT_W-1:0]     idx_r;
  logic                            is_tick_r;

  // Running best candidate of the scan, with what the fix-up cycle needs of it.
  logic                            found_r;
  logic [plls_pkg::SLOT_W-1:0]     best_r;
  logic signed [plls_pkg::LAX_W-1:0] best_lax_r;
  logic [plls_pkg::TIME_W-1:0]     best_rw_r;
  logic                            best_rw_one_r;
  logic                            best_reload_r;
  logic [plls_pkg::JOB_W-1:0]      best_job_r;
  logic [plls_pkg::MAX_TASKS-1:0]  miss_r;

  logic                            out_valid_r;
  logic [plls_pkg::SLOT_W-1:0]     out_chosen_r;
  logic                            out_idle_r;
  logic [plls_pkg::JOB_W-1:0]      out_job_r;
  logic [plls_pkg::MAX_TASKS-1:0]  out_miss_r;

  plls_pkg::entry_t                entry_r [plls_pkg::MAX_TASKS];

  logic [plls_pkg::CNT_W-1:0]      n_sat;
  logic                            accept;
  logic                            last_slot;
  logic                            out_free;
  logic                            issue;
  plls_pkg::step_t                 step;

  // The number of slots taking part saturates at the table size.
  assign n_sat = (tasks_in_use_r > plls_pkg::CFG_W'(plls_pkg::MAX_TASKS))
               ? plls_pkg::CNT_W'(plls_pkg::MAX_TASKS)
               : plls_pkg::CNT_W'(tasks_in_use_r);

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_slot = ((plls_pkg::CNT_W'(idx_r) + 1'b1) == n_r);
  assign out_free  = !out_valid_r || out_ready;
  assign issue     = (state_r == S_ISSUE) && out_free;

  assign out_valid       = out_valid_r;
  assign out_chosen_task = out_chosen_r;
  assign out_idle        = out_idle_r;
  assign out_job_number  = out_job_r;
  assign out_miss_mask   = out_miss_r;

  // The one shared step unit works on the slot that the scan index points at.
  plls_step u_step (
    .cur      (entry_r[idx_r]),
    .found    (found_r),
    .best_lax (best_lax_r),
    .res      (step)
  );

  // Task table. A load writes a whole entry and starts job 1; the scan writes
  // back the counted-down entry; the fix-up cycle charges one tick of work to
  // the chosen slot unless that slot was just reloaded.
  always_ff @(posedge clk) begin
    if (accept && (in_cmd == plls_pkg::CMD_LOAD)) begin
      entry_r[in_task_slot].exec_len     <= in_exec_time;
      entry_r[in_task_slot].period_len   <= in_period_len;
      entry_r[in_task_slot].deadline_len <= in_deadline_len;
      entry_r[in_task_slot].rw           <= in_exec_time;
      entry_r[in_task_slot].pl           <= in_period_len;
      entry_r[in_task_slot].dl           <= {1'b0, in_deadline_len};
      entry_r[in_task_slot].job          <= plls_pkg::JOB_W'(1);
    end else if (state_r == S_SCAN) begin
      entry_r[idx_r] <= step.nxt;
    end else if ((state_r == S_FIX) && found_r && !best_reload_r) begin
      entry_r[best_r].rw <= best_rw_r - 1'b1;
    end
  end

  // Sequencer, configuration register and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      tasks_in_use_r <= plls_pkg::CFG_W'(1);
      out_valid_r    <= 1'b0;
      found_r        <= 1'b0;
      is_tick_r      <= 1'b0;
      idx_r          <= '0;
      n_r            <= '0;
      miss_r         <= '0;
    end else begin
      if (cfg_we) begin
        tasks_in_use_r <= cfg_wdata;
      end
      // A result taken in the cycle a new one issues is replaced, not cleared.
      if (out_valid_r && out_ready && !issue) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            is_tick_r <= (in_cmd == plls_pkg::CMD_TICK);
            found_r   <= 1'b0;
            miss_r    <= '0;
            idx_r     <= '0;
            n_r       <= n_sat;
            if ((in_cmd == plls_pkg::CMD_TICK) && (n_sat != '0)) begin
              state_r <= S_SCAN;
            end else if (in_cmd == plls_pkg::CMD_TICK) begin
              state_r <= S_FIX;
            end else begin
              state_r <= S_ISSUE;
            end
          end
        end
        S_SCAN: begin
          if (step.take) begin
            found_r       <= 1'b1;
            best_r        <= idx_r;
            best_lax_r    <= step.lax;
            best_rw_r     <= entry_r[idx_r].rw;
            best_rw_one_r <= step.rw_one;
            best_reload_r <= step.reload;
            best_job_r    <= step.nxt.job;
          end
          miss_r[idx_r] <= step.miss;
          idx_r         <= idx_r + 1'b1;
          if (last_slot) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          // The miss test sees the chosen slot's work after its decrement.
          if (found_r && best_rw_one_r) begin
            miss_r[best_r] <= 1'b0;
          end
          state_r <= S_ISSUE;
        end
        S_ISSUE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (is_tick_r && found_r) begin
              out_chosen_r <= best_r;
              out_idle_r   <= 1'b0;
              out_job_r    <= best_job_r;
            end else begin
              out_chosen_r <= '0;
              out_idle_r   <= is_tick_r;
              out_job_r    <= '0;
            end
            out_miss_r <= is_tick_r ? miss_r : '0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "request accepted while busy")
  `ASSERT_SAME(a_scan_in_range, state_r == S_SCAN, plls_pkg::CNT_W'(idx_r) < n_r,
    "scan index beyond the slots in use")
  `ASSERT_SAME(a_best_behind_scan, (state_r == S_SCAN) && found_r, best_r < idx_r,
    "best slot not behind the scan index")
  `ASSERT_SAME(a_idle_result_clean, out_valid && out_idle,
    (out_chosen_task == '0) && (out_job_number == '0), "idle result carries a task")

endmodule
